[src/cbf_pkg.sv]
package cbf_pkg;

  // Width of split counts and point indexes (MAX_SPLITS is at most 64).
  localparam int CNT_W = 7;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIFF,
    F_CMP,
    F_SEARCH,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_MUL,
    B_ADD,
    B_EMIT
  } back_state_t;

  // Per-segment control that travels with the coordinates through the queue.
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic             clipped;
  } seg_ctl_t;

endpackage

[src/cbf_queue.sv]
module cbf_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push && !full) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if ((push && !full) && !(pop && !empty)) begin
      count_nxt = count_r + 2'd1;
    end else if (!(push && !full) && (pop && !empty)) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/cbf_front.sv]
module cbf_front #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8,
  parameter int MAX_SPLITS  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [15:0]                   flatness,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_ctrl1_x,
  input  logic signed [COORD_WIDTH-1:0] in_ctrl1_y,
  input  logic signed [COORD_WIDTH-1:0] in_ctrl2_x,
  input  logic signed [COORD_WIDTH-1:0] in_ctrl2_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  input  logic                          in_ctrl1_active,
  input  logic                          in_ctrl2_active,
  output logic                          q_push,
  output logic [8*COORD_WIDTH-1:0]      q_coords,
  output cbf_pkg::seg_ctl_t             q_ctl,
  input  logic                          q_full
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 2;                  // second difference
  localparam int SW = CW + 3;                  // L1 norm
  localparam int TW = (CW + 5 > 32) ? CW + 5 : 32;  // 3*D and threshold
  localparam int CNT_W = cbf_pkg::CNT_W;

  cbf_pkg::front_state_t state_r, state_nxt;

  logic signed [CW-1:0] p_r [8];
  logic [SW-1:0]        d1_r, d1_nxt;
  logic [SW-1:0]        d2_r, d2_nxt;
  logic [CW:0]          span_r, span_nxt;
  logic [TW-1:0]        d3_r, d3_nxt;
  logic [TW-1:0]        thr_r, thr_nxt;
  logic [2:0]           k_r, k_nxt;
  cbf_pkg::seg_ctl_t    ctl_r, ctl_nxt;

  logic                 accept;
  logic signed [DW-1:0] sx1, sy1, sx2, sy2;
  logic [DW-1:0]        ax1, ay1, ax2, ay2;
  logic signed [CW:0]   ex, ey;
  logic [CW:0]          mx, my;
  logic [SW-1:0]        dmax;
  logic [TW-1:0]        d3_c;
  logic [CW+1:0]        req;
  logic [7:0]           cand;

  assign in_stall = (state_r != cbf_pkg::F_IDLE);
  assign accept   = in_valid && !in_stall;

  // Effective control points are captured on accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      p_r[0] <= in_start_x;
      p_r[1] <= in_start_y;
      p_r[2] <= in_ctrl1_active ? in_ctrl1_x : in_start_x;
      p_r[3] <= in_ctrl1_active ? in_ctrl1_y : in_start_y;
      p_r[4] <= in_ctrl2_active ? in_ctrl2_x : in_end_x;
      p_r[5] <= in_ctrl2_active ? in_ctrl2_y : in_end_y;
      p_r[6] <= in_end_x;
      p_r[7] <= in_end_y;
    end
  end

  // Second differences and endpoint span.
  always_comb begin
    sx1 = DW'(p_r[0]) - (DW'(p_r[2]) <<< 1) + DW'(p_r[4]);
    sy1 = DW'(p_r[1]) - (DW'(p_r[3]) <<< 1) + DW'(p_r[5]);
    sx2 = DW'(p_r[2]) - (DW'(p_r[4]) <<< 1) + DW'(p_r[6]);
    sy2 = DW'(p_r[3]) - (DW'(p_r[5]) <<< 1) + DW'(p_r[7]);
    ax1 = sx1[DW-1] ? DW'(-sx1) : DW'(sx1);
    ay1 = sy1[DW-1] ? DW'(-sy1) : DW'(sy1);
    ax2 = sx2[DW-1] ? DW'(-sx2) : DW'(sx2);
    ay2 = sy2[DW-1] ? DW'(-sy2) : DW'(sy2);
    d1_nxt = SW'(ax1) + SW'(ay1);
    d2_nxt = SW'(ax2) + SW'(ay2);
    ex = (CW+1)'(p_r[6]) - (CW+1)'(p_r[0]);
    ey = (CW+1)'(p_r[7]) - (CW+1)'(p_r[1]);
    mx = ex[CW] ? (CW+1)'(-ex) : (CW+1)'(ex);
    my = ey[CW] ? (CW+1)'(-ey) : (CW+1)'(ey);
    span_nxt = (mx > my) ? mx : my;
  end

  assign dmax = (d1_r > d2_r) ? d1_r : d2_r;
  assign d3_c = TW'(dmax) + (TW'(dmax) << 1);
  assign req  = (CW+2)'(1) + ((CW+2)'(span_r) << 1 >> FRAC_BITS);
  assign cand = 8'd1 + (8'd1 << k_r);

  // Split count sequencer.
  always_comb begin
    state_nxt = state_r;
    d3_nxt    = d3_r;
    thr_nxt   = thr_r;
    k_nxt     = k_r;
    ctl_nxt   = ctl_r;
    q_push    = 1'b0;
    case (state_r)
      cbf_pkg::F_IDLE: begin
        if (accept && (in_ctrl1_active || in_ctrl2_active)) begin
          state_nxt = cbf_pkg::F_DIFF;
        end
      end
      cbf_pkg::F_DIFF: begin
        state_nxt = cbf_pkg::F_CMP;
      end
      cbf_pkg::F_CMP: begin
        if (flatness == 16'd0) begin
          if (req > (CW+2)'(MAX_SPLITS)) begin
            ctl_nxt.n       = CNT_W'(MAX_SPLITS);
            ctl_nxt.clipped = 1'b1;
          end else begin
            ctl_nxt.n       = req[CNT_W-1:0];
            ctl_nxt.clipped = 1'b0;
          end
          state_nxt = cbf_pkg::F_PUSH;
        end else if (d3_c <= TW'(flatness)) begin
          ctl_nxt.n       = CNT_W'(1);
          ctl_nxt.clipped = 1'b0;
          state_nxt       = cbf_pkg::F_PUSH;
        end else begin
          d3_nxt    = d3_c;
          thr_nxt   = TW'(flatness) << 2;
          k_nxt     = 3'd0;
          state_nxt = cbf_pkg::F_SEARCH;
        end
      end
      cbf_pkg::F_SEARCH: begin
        // One power of four per cycle.
        if (cand > 8'(MAX_SPLITS)) begin
          ctl_nxt.n       = CNT_W'(MAX_SPLITS);
          ctl_nxt.clipped = 1'b1;
          state_nxt       = cbf_pkg::F_PUSH;
        end else if (thr_r >= d3_r) begin
          ctl_nxt.n       = cand[CNT_W-1:0];
          ctl_nxt.clipped = 1'b0;
          state_nxt       = cbf_pkg::F_PUSH;
        end else begin
          thr_nxt = thr_r << 2;
          k_nxt   = k_r + 3'd1;
        end
      end
      cbf_pkg::F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = cbf_pkg::F_IDLE;
        end
      end
      default: begin
        state_nxt = cbf_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbf_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d1_r   <= d1_nxt;
    d2_r   <= d2_nxt;
    span_r <= span_nxt;
    d3_r   <= d3_nxt;
    thr_r  <= thr_nxt;
    k_r    <= k_nxt;
    ctl_r  <= ctl_nxt;
  end

  assign q_ctl    = ctl_r;
  assign q_coords = {p_r[7], p_r[6], p_r[5], p_r[4], p_r[3], p_r[2], p_r[1], p_r[0]};

endmodule

[src/cbf_back.sv]
module cbf_back #(
  parameter int COORD_WIDTH = 24,
  parameter int T_BITS      = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic [8*COORD_WIDTH-1:0]      q_coords,
  input  cbf_pkg::seg_ctl_t             q_ctl,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_point_x,
  output logic signed [COORD_WIDTH-1:0] out_point_y,
  output logic [cbf_pkg::CNT_W-1:0]     out_point_index,
  output logic                          out_last_point,
  output logic                          out_count_clipped
);

  localparam int CW    = COORD_WIDTH;
  localparam int PW    = CW + T_BITS + 2;
  localparam int CNT_W = cbf_pkg::CNT_W;
  localparam int BC_W  = $clog2(T_BITS);

  cbf_pkg::back_state_t state_r, state_nxt;

  logic [8*CW-1:0]      seg_r, seg_nxt;
  cbf_pkg::seg_ctl_t    ctl_r, ctl_nxt;
  logic [CNT_W-1:0]     j_r, j_nxt;
  logic [7:0]           rem_r, rem_nxt;
  logic [T_BITS-1:0]    t_r, t_nxt;
  logic [BC_W-1:0]      bit_r, bit_nxt;
  logic [2:0]           step_r, step_nxt;
  logic signed [CW-1:0] qx_r [4];
  logic signed [CW-1:0] qy_r [4];
  logic signed [CW-1:0] qx_nxt [4];
  logic signed [CW-1:0] qy_nxt [4];
  logic signed [PW-1:0] px_r, py_r, px_nxt, py_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [CW-1:0] ox_r, oy_r, ox_nxt, oy_nxt;
  logic [CNT_W-1:0]     oi_r, oi_nxt;
  logic                 ol_r, ol_nxt, oc_r, oc_nxt;

  logic [7:0]           divisor, rem2;
  logic signed [CW-1:0] ax, bx, ay, by;
  logic signed [CW:0]   dx, dy;
  logic signed [PW-1:0] shx, shy;
  logic [1:0]           wsel;
  logic [8*CW-1:0]      src;
  logic                 load_q;

  assign divisor = 8'(ctl_r.n) + 8'd1;
  assign rem2    = {rem_r[6:0], 1'b0};

  // Operand pairs of the de Casteljau steps.
  always_comb begin
    case (step_r)
      3'd1, 3'd4: begin
        ax = qx_r[1]; bx = qx_r[2]; ay = qy_r[1]; by = qy_r[2]; wsel = 2'd1;
      end
      3'd2: begin
        ax = qx_r[2]; bx = qx_r[3]; ay = qy_r[2]; by = qy_r[3]; wsel = 2'd2;
      end
      default: begin
        ax = qx_r[0]; bx = qx_r[1]; ay = qy_r[0]; by = qy_r[1]; wsel = 2'd0;
      end
    endcase
    dx  = (CW+1)'(bx) - (CW+1)'(ax);
    dy  = (CW+1)'(by) - (CW+1)'(ay);
    shx = px_r >>> T_BITS;
    shy = py_r >>> T_BITS;
  end

  // Point sequencer: divider, then shared interpolation units, then output.
  always_comb begin
    state_nxt     = state_r;
    seg_nxt       = seg_r;
    ctl_nxt       = ctl_r;
    j_nxt         = j_r;
    rem_nxt       = rem_r;
    t_nxt         = t_r;
    bit_nxt       = bit_r;
    step_nxt      = step_r;
    px_nxt        = PW'(dx) * PW'($signed({1'b0, t_r}));
    py_nxt        = PW'(dy) * PW'($signed({1'b0, t_r}));
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    out_valid_nxt = out_valid_r && out_stall;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    oi_nxt        = oi_r;
    ol_nxt        = ol_r;
    oc_nxt        = oc_r;
    q_pop         = 1'b0;
    load_q        = 1'b0;
    src           = seg_r;
    case (state_r)
      cbf_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          seg_nxt   = q_coords;
          ctl_nxt   = q_ctl;
          src       = q_coords;
          load_q    = 1'b1;
          j_nxt     = CNT_W'(1);
          rem_nxt   = 8'd1;
          state_nxt = cbf_pkg::B_DIV;
        end
      end
      cbf_pkg::B_DIV: begin
        // One quotient bit of t = j * 2^T / (n + 1) per cycle.
        if (rem2 >= divisor) begin
          rem_nxt = rem2 - divisor;
          t_nxt   = {t_r[T_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = rem2;
          t_nxt   = {t_r[T_BITS-2:0], 1'b0};
        end
        bit_nxt = bit_r + BC_W'(1);
        if (bit_r == BC_W'(T_BITS - 1)) begin
          step_nxt  = 3'd0;
          state_nxt = cbf_pkg::B_MUL;
        end
      end
      cbf_pkg::B_MUL: begin
        state_nxt = cbf_pkg::B_ADD;
      end
      cbf_pkg::B_ADD: begin
        qx_nxt[wsel] = ax + shx[CW-1:0];
        qy_nxt[wsel] = ay + shy[CW-1:0];
        step_nxt     = step_r + 3'd1;
        state_nxt    = (step_r == 3'd5) ? cbf_pkg::B_EMIT : cbf_pkg::B_MUL;
      end
      cbf_pkg::B_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          ox_nxt        = qx_r[0];
          oy_nxt        = qy_r[0];
          oi_nxt        = j_r;
          ol_nxt        = (j_r == ctl_r.n);
          oc_nxt        = ctl_r.clipped;
          if (j_r == ctl_r.n) begin
            state_nxt = cbf_pkg::B_IDLE;
          end else begin
            j_nxt     = j_r + CNT_W'(1);
            rem_nxt   = 8'(j_r) + 8'd1;
            load_q    = 1'b1;
            state_nxt = cbf_pkg::B_DIV;
          end
        end
      end
      default: begin
        state_nxt = cbf_pkg::B_IDLE;
      end
    endcase
    // Every point starts again from the segment's control points.
    if (load_q) begin
      bit_nxt = '0;
      t_nxt   = '0;
      for (int i = 0; i < 4; i++) begin
        qx_nxt[i] = src[(2*i)*CW +: CW];
        qy_nxt[i] = src[(2*i+1)*CW +: CW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbf_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r  <= seg_nxt;
    ctl_r  <= ctl_nxt;
    j_r    <= j_nxt;
    rem_r  <= rem_nxt;
    t_r    <= t_nxt;
    bit_r  <= bit_nxt;
    step_r <= step_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    qx_r   <= qx_nxt;
    qy_r   <= qy_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    oi_r   <= oi_nxt;
    ol_r   <= ol_nxt;
    oc_r   <= oc_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_point_x       = ox_r;
  assign out_point_y       = oy_r;
  assign out_point_index   = oi_r;
  assign out_last_point    = ol_r;
  assign out_count_clipped = oc_r;

endmodule

[src/cubic_bezier_flattener.sv]
// Channel  Direction  Handshake              Content
// in       input      in_valid / in_stall    one cubic segment and control flags
// out      output     out_valid / out_stall  one point on the curve
// cfg      input      cfg_valid / cfg_ready  flatness tolerance, unsigned 8.8
//
// The front takes a segment and fixes its split count, searching a threshold
// where needed; a two-entry queue hands it to the back. A segment with
// neither control active yields no points. For each point the back's divider
// makes one quotient bit per cycle, then six multiply/add pairs follow.
// Reset is synchronous, active low; flatness returns to 256 (1.0). A stalled
// output holds its point while the front takes segments till the queue fills.
module cubic_bezier_flattener #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8,
  parameter int MAX_SPLITS  = 64,
  parameter int T_BITS      = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [15:0]                   cfg_flatness,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_ctrl1_x,
  input  logic signed [COORD_WIDTH-1:0] in_ctrl1_y,
  input  logic signed [COORD_WIDTH-1:0] in_ctrl2_x,
  input  logic signed [COORD_WIDTH-1:0] in_ctrl2_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  input  logic                          in_ctrl1_active,
  input  logic                          in_ctrl2_active,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_point_x,
  output logic signed [COORD_WIDTH-1:0] out_point_y,
  output logic [cbf_pkg::CNT_W-1:0]     out_point_index,
  output logic                          out_last_point,
  output logic                          out_count_clipped
);

  localparam int QW = 8 * COORD_WIDTH + $bits(cbf_pkg::seg_ctl_t);

  logic [15:0]                flatness_r;
  logic                       q_push, q_pop, q_full, q_empty;
  logic [8*COORD_WIDTH-1:0]   f_coords, b_coords;
  cbf_pkg::seg_ctl_t          f_ctl, b_ctl;
  logic [QW-1:0]              q_out;

  // Flatness register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flatness_r <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      flatness_r <= cfg_flatness;
    end
  end

  cbf_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .MAX_SPLITS (MAX_SPLITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .flatness       (flatness_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_ctrl1_x     (in_ctrl1_x),
    .in_ctrl1_y     (in_ctrl1_y),
    .in_ctrl2_x     (in_ctrl2_x),
    .in_ctrl2_y     (in_ctrl2_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_ctrl1_active(in_ctrl1_active),
    .in_ctrl2_active(in_ctrl2_active),
    .q_push         (q_push),
    .q_coords       (f_coords),
    .q_ctl          (f_ctl),
    .q_full         (q_full)
  );

  cbf_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data({f_ctl, f_coords}),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_out),
    .empty    (q_empty)
  );

  assign b_coords = q_out[8*COORD_WIDTH-1:0];
  assign b_ctl    = q_out[QW-1:8*COORD_WIDTH];

  cbf_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .T_BITS     (T_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .q_coords         (b_coords),
    .q_ctl            (b_ctl),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_point_index  (out_point_index),
    .out_last_point   (out_last_point),
    .out_count_clipped(out_count_clipped)
  );

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("segment pushed into full queue");

  // Point indexes stay within the split range.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_point_index != '0) &&
                  (out_point_index <= cbf_pkg::CNT_W'(MAX_SPLITS)))
    else $error("point index out of range");

  // After a segment's last point is taken, the next point starts a segment.
  a_new_segment: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_point |=>
      !out_valid || (out_point_index == cbf_pkg::CNT_W'(1)))
    else $error("segment did not restart at index one");

endmodule

[test/cubic_bezier_flattener_checker.sv]
`timescale 1ns / 100ps

module cubic_bezier_flattener_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [15:0]        cfg_flatness,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [23:0] in_start_x,
  input  logic signed [23:0] in_start_y,
  input  logic signed [23:0] in_ctrl1_x,
  input  logic signed [23:0] in_ctrl1_y,
  input  logic signed [23:0] in_ctrl2_x,
  input  logic signed [23:0] in_ctrl2_y,
  input  logic signed [23:0] in_end_x,
  input  logic signed [23:0] in_end_y,
  input  logic               in_ctrl1_active,
  input  logic               in_ctrl2_active,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [23:0] out_point_x,
  input  logic signed [23:0] out_point_y,
  input  logic [6:0]         out_point_index,
  input  logic               out_last_point,
  input  logic               out_count_clipped,
  output int                 fail_count,
  output int                 pending_points,
  output int                 point_count,
  output int                 clip_count
);

  localparam int MAX_SPLITS = 64;
  localparam int T_BITS     = 16;
  localparam int FRAC_BITS  = 8;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [6:0]         index;
    logic               last;
    logic               clipped;
  } curve_point_t;

  curve_point_t point_queue[$];
  logic [15:0]  flat_tol;

  assign pending_points = point_queue.size();

  // One interpolation step, floor of the scaled difference.
  function automatic longint interp(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> T_BITS);
  endfunction

  function automatic longint casteljau(longint c0, longint c1, longint c2, longint c3,
                                       longint t);
    longint q0, q1, q2;
    q0 = interp(c0, c1, t);
    q1 = interp(c1, c2, t);
    q2 = interp(c2, c3, t);
    q0 = interp(q0, q1, t);
    q1 = interp(q1, q2, t);
    return interp(q0, q1, t);
  endfunction

  function automatic longint absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Work out the split count and queue the points of one segment.
  task automatic predict_points(longint px[4], longint py[4]);
    longint n, d1, d2, d3, span, req, cand, t;
    logic   clipped;
    n = 1;
    clipped = 1'b0;
    if (flat_tol == 0) begin
      span = absval(px[3] - px[0]);
      if (absval(py[3] - py[0]) > span) span = absval(py[3] - py[0]);
      req = 1 + ((2 * span) >>> FRAC_BITS);
      if (req > MAX_SPLITS) begin
        n = MAX_SPLITS;
        clipped = 1'b1;
      end else begin
        n = req;
      end
    end else begin
      d1 = absval(px[0] - 2 * px[1] + px[2]) + absval(py[0] - 2 * py[1] + py[2]);
      d2 = absval(px[1] - 2 * px[2] + px[3]) + absval(py[1] - 2 * py[2] + py[3]);
      d3 = 3 * (d1 > d2 ? d1 : d2);
      if (d3 > flat_tol) begin
        n = MAX_SPLITS;
        clipped = 1'b1;
        for (int k = 0; k < 8; k++) begin
          cand = 1 + (longint'(1) << k);
          if (cand > MAX_SPLITS) break;
          if (((longint'(4) * flat_tol) << (2 * k)) >= d3) begin
            n = cand;
            clipped = 1'b0;
            break;
          end
        end
      end
    end
    for (longint j = 1; j <= n; j++) begin
      curve_point_t p;
      t = (j << T_BITS) / (n + 1);
      p.x = 24'(casteljau(px[0], px[1], px[2], px[3], t));
      p.y = 24'(casteljau(py[0], py[1], py[2], py[3], t));
      p.index = 7'(j);
      p.last = (j == n);
      p.clipped = clipped;
      point_queue.push_back(p);
    end
  endtask

  always @(posedge clk) begin
    longint px[4], py[4];
    curve_point_t want;
    if (!rst_n) begin
      flat_tol <= 16'd256;
      point_queue.delete();
      fail_count <= 0;
      point_count <= 0;
      clip_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) flat_tol <= cfg_flatness;
      // Capture a segment, with inactive controls replaced by endpoints.
      if (in_valid && !in_stall && (in_ctrl1_active || in_ctrl2_active)) begin
        px[0] = in_start_x;
        py[0] = in_start_y;
        px[3] = in_end_x;
        py[3] = in_end_y;
        px[1] = in_ctrl1_active ? longint'(in_ctrl1_x) : px[0];
        py[1] = in_ctrl1_active ? longint'(in_ctrl1_y) : py[0];
        px[2] = in_ctrl2_active ? longint'(in_ctrl2_x) : px[3];
        py[2] = in_ctrl2_active ? longint'(in_ctrl2_y) : py[3];
        predict_points(px, py);
      end
      // Compare each delivered point with the oldest prediction.
      if (out_valid && !out_stall) begin
        point_count <= point_count + 1;
        if (out_count_clipped) clip_count <= clip_count + 1;
        if (point_queue.size() == 0) begin
          $display("%0t: unexpected point x=%0d y=%0d j=%0d", $time, out_point_x,
                   out_point_y, out_point_index);
          fail_count <= fail_count + 1;
        end else begin
          want = point_queue.pop_front();
          if (want.x !== out_point_x || want.y !== out_point_y ||
              want.index !== out_point_index || want.last !== out_last_point ||
              want.clipped !== out_count_clipped) begin
            $display("%0t: expected x=%0d y=%0d j=%0d last=%0b clip=%0b", $time,
                     want.x, want.y, want.index, want.last, want.clipped);
            $display("%0t: actual   x=%0d y=%0d j=%0d last=%0b clip=%0b", $time,
                     out_point_x, out_point_y, out_point_index, out_last_point,
                     out_count_clipped);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[test/cubic_bezier_flattener_test.sv]
`timescale 1ns / 100ps

module cubic_bezier_flattener_test;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [15:0]        cfg_flatness;
  logic               in_valid;
  logic               in_stall;
  logic signed [23:0] in_start_x, in_start_y, in_ctrl1_x, in_ctrl1_y;
  logic signed [23:0] in_ctrl2_x, in_ctrl2_y, in_end_x, in_end_y;
  logic               in_ctrl1_active, in_ctrl2_active;
  logic               out_valid;
  logic               out_stall;
  logic signed [23:0] out_point_x, out_point_y;
  logic [6:0]         out_point_index;
  logic               out_last_point, out_count_clipped;
  int                 fail_count, pending_points, point_count, clip_count;
  int                 segment_count;
  int                 hold_cycles;
  int                 wait_cycles;
  logic               hold_start;
  logic               hold_used;

  cubic_bezier_flattener u_dut (.*);

  cubic_bezier_flattener_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("cubic_bezier_flattener_test NOT OK");
    $finish;
  end

  // Offer one segment and hold it until the block takes it.
  task automatic send_segment(logic signed [23:0] c[8], logic a1, logic a2);
    int gap;
    gap = $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_x <= c[0];
    in_start_y <= c[1];
    in_ctrl1_x <= c[2];
    in_ctrl1_y <= c[3];
    in_ctrl2_x <= c[4];
    in_ctrl2_y <= c[5];
    in_end_x <= c[6];
    in_end_y <= c[7];
    in_ctrl1_active <= a1;
    in_ctrl2_active <= a2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    segment_count++;
  endtask

  // Withdraw the offer once the last segment has been taken.
  task automatic stop_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Let the block finish, then write the flatness register.
  task automatic set_flatness(logic [15:0] value);
    stop_input();
    while (pending_points != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_flatness <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random segment; the spread keeps most curves in moderate split counts.
  task automatic random_segment();
    logic signed [23:0] c[8];
    int spread;
    spread = $urandom_range(0, 3);
    for (int i = 0; i < 8; i++) begin
      case (spread)
        0: c[i] = 24'($urandom);
        1: c[i] = $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
        2: c[i] = $signed(24'($urandom_range(0, 255))) - 24'sd128;
        default: c[i] = $signed(24'($urandom_range(0, 131071))) - 24'sd65536;
      endcase
    end
    send_segment(c, $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0);
  endtask

  // Receiver: a drawn wait after each point while segment_count mod 50 is under 35, one long hold-off on request.
  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cycles <= 0;
      hold_used <= 1'b0;
      wait_cycles <= 0;
    end else if (hold_start && !hold_used) begin
      hold_used <= 1'b1;
      hold_cycles <= 3000;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (wait_cycles > 0) begin
      wait_cycles <= wait_cycles - 1;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      gap = (segment_count % 50 < 35) ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        wait_cycles <= gap - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    logic signed [23:0] c[8];
    logic [15:0] flat_list[5];
    int wait_limit;
    flat_list = '{16'd0, 16'hFFFF, 16'd1, 16'd40, 16'd256};
    segment_count = 0;
    hold_start = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_flatness = 16'd0;
    in_valid = 1'b0;
    {in_start_x, in_start_y, in_ctrl1_x, in_ctrl1_y} = '0;
    {in_ctrl2_x, in_ctrl2_y, in_end_x, in_end_y} = '0;
    in_ctrl1_active = 1'b0;
    in_ctrl2_active = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, straight segment, flat curve, huge bends.
    c = '{24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF,
          24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF};
    send_segment(c, 1, 1);
    send_segment(c, 0, 0);
    send_segment(c, 1, 0);
    send_segment(c, 0, 1);
    c = '{24'sd0, 24'sd0, 24'sd100, 24'sd100, 24'sd200, 24'sd200, 24'sd300, 24'sd300};
    send_segment(c, 1, 1);
    c = '{24'sd0, 24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'sd0};
    send_segment(c, 1, 1);
    c = '{24'sh800000, 24'sd0, 24'sd0, 24'sh7FFFFF, 24'sd0, 24'sh800000,
          24'sh7FFFFF, 24'sd0};
    send_segment(c, 1, 1);
    c = '{24'sd5, 24'sd7, 24'sd9, 24'sd11, 24'sd13, 24'sd15, 24'sd17, 24'sd19};
    send_segment(c, 0, 0);
    c = '{-24'sd1, -24'sd1, 24'sd1, 24'sd1, -24'sd1, -24'sd1, 24'sd1, 24'sd1};
    send_segment(c, 1, 1);

    // Random phases across several flatness settings.
    for (int phase = 0; phase < 5; phase++) begin
      set_flatness(flat_list[phase]);
      for (int i = 0; i < 84; i++) begin
        if (phase == 2 && i == 10) begin
          hold_start <= 1'b1;
        end
        if (phase == 3 && i == 40) begin
          stop_input();
          while (pending_points != 0) @(posedge clk);
        end
        random_segment();
      end
    end

    stop_input();
    wait_limit = 0;
    while (pending_points != 0 && wait_limit < 2000000) begin
      @(posedge clk);
      wait_limit++;
    end
    repeat (3000) @(posedge clk);
    $display("Sent %0d segments over five flatness settings; checked %0d points, %0d clipped.",
             segment_count, point_count, clip_count);
    if (fail_count == 0 && pending_points == 0) begin
      $display("cubic_bezier_flattener_test OK");
    end else begin
      $display("cubic_bezier_flattener_test NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
src/cbf_pkg.sv
src/cbf_queue.sv
src/cbf_front.sv
src/cbf_back.sv
src/cubic_bezier_flattener.sv
test/cubic_bezier_flattener_checker.sv
test/cubic_bezier_flattener_test.sv
